@@ hw/rtl/bitmap_contiguous_block_allocator_defines.svh @@
// Assertion macros for the bitmap block allocator.
// Used by modules that hold clk_i and rst_ni; no other dependencies.
`ifndef BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

// Condition must hold on every clock outside reset.
`define BCBA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Trigger implies consequence on the following clock.
`define BCBA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bcba_pkg.sv @@
// Shared types and constants for the bitmap block allocator.
// No dependencies.
package bcba_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 1024;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned START_W  = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned RUNS_W   = 10;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // Control from the sequencer to the ring of map cells.
  typedef struct packed {
    logic shift;
    logic tail_bit;
  } ring_ctl_t;

endpackage

@@ hw/rtl/bcba_cell.sv @@
// One usage bit of the block map; shifts toward the head of the ring.
// Depends on nothing but the clock and reset.
module bcba_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic d_i,
  output logic q_o
);

  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (shift_i) begin
      bit_q <= d_i;
    end
  end

  assign q_o = bit_q;

endmodule

@@ hw/rtl/bcba_ctrl.sv @@
// Sequencer: watches the head cell of the rotating map, rewrites the tail,
// keeps the free count and builds the result. Uses bcba_pkg and the defines.
`include "bitmap_contiguous_block_allocator_defines.svh"

module bcba_ctrl import bcba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     in_op_i,
  input  logic [START_W-1:0]  in_start_i,
  input  logic [COUNT_W-1:0]  in_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_W-1:0]    out_data_o,
  input  logic                head_i,
  output ring_ctl_t           ring_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned W     = (IDX_W + 2 > 12) ? IDX_W + 2 : 12;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BLOCKS - 1);
  localparam logic [W-1:0]     TOTAL = W'(NUM_BLOCKS);

  state_e state_q, state_d;
  op_e    op_q, op_d;
  status_e status_q, status_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic pass2_q, pass2_d, found_q, found_d;
  logic [W-1:0] start_q, start_d, count_q, count_d, lim_q, lim_d;
  logic [W-1:0] free_q, free_d, run_q, run_d, first_q, first_d;
  logic [W-1:0] largest_q, largest_d, runs_q, runs_d, total_q, total_d;
  logic [COUNT_W-1:0] rsv_q;
  logic out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic accept, wrap, in_rng, head_free;
  logic [W-1:0] idx_w, cnt_in, sum;
  logic [W-1:0] run_inc;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign wrap      = (idx_q == LAST);
  assign idx_w     = W'(idx_q);
  assign cnt_in    = W'(in_count_i);
  assign sum       = free_q + cnt_in;
  assign head_free = !head_i;
  assign run_inc   = run_q + W'(1);
  assign in_rng    = (idx_w >= start_q) && ((idx_w - start_q) < count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((in_op_i == OP_ALLOC || in_op_i == OP_FREE) && cnt_in == '0) begin
            state_d = S_DONE;
          end else if (in_op_i == OP_ALLOC && cnt_in > free_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (wrap && !(op_q == OP_ALLOC && !pass2_q && found_d)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_d = op_q; status_d = status_q; idx_d = idx_q; pass2_d = pass2_q;
    found_d = found_q; start_d = start_q; count_d = count_q; lim_d = lim_q;
    free_d = free_q; run_d = run_q; first_d = first_q; largest_d = largest_q;
    runs_d = runs_q; total_d = total_q;
    ring_o.shift = (state_q == S_SCAN);
    ring_o.tail_bit = head_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_e'(in_op_i);
          status_d = ST_OK;
          idx_d = '0; pass2_d = 1'b0; found_d = 1'b0;
          run_d = '0; first_d = '0; largest_d = '0; runs_d = '0; total_d = '0;
          count_d = cnt_in;
          start_d = (in_op_i == OP_FREE) ? W'(in_start_i) : '0;
          lim_d = (W'(rsv_q) > TOTAL) ? TOTAL : W'(rsv_q);
          case (op_e'(in_op_i))
            OP_INIT: free_d = TOTAL - lim_d;
            OP_ALLOC: begin
              if (cnt_in == '0) begin
                status_d = ST_INVALID;
              end else if (cnt_in > free_q) begin
                status_d = ST_NOSPACE;
              end
            end
            OP_FREE: begin
              if (cnt_in == '0) begin
                status_d = ST_INVALID;
              end else begin
                free_d = (sum > TOTAL) ? TOTAL : sum;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        idx_d = wrap ? '0 : idx_q + IDX_W'(1);
        case (op_q)
          OP_INIT: ring_o.tail_bit = (idx_w < lim_q);
          OP_FREE: ring_o.tail_bit = in_rng ? 1'b0 : head_i;
          OP_ALLOC: begin
            if (pass2_q) begin
              ring_o.tail_bit = in_rng ? 1'b1 : head_i;
              if (wrap) begin
                free_d = free_q - count_q;
              end
            end else begin
              if (!found_q) begin
                if (head_free) begin
                  run_d = run_inc;
                  if (run_q == '0) begin
                    first_d = idx_w;
                  end
                  if (run_inc == count_q) begin
                    found_d = 1'b1;
                    start_d = (run_q == '0) ? idx_w : first_q;
                  end
                end else begin
                  run_d = '0;
                end
              end
              if (wrap) begin
                if (found_d) begin
                  pass2_d = 1'b1;
                end else begin
                  status_d = ST_NOSPACE;
                end
              end
            end
          end
          default: begin
            // query: run statistics
            if (head_free) begin
              total_d = total_q + W'(1);
              run_d = run_inc;
              if (run_q == '0) begin
                runs_d = runs_q + W'(1);
              end
              if (run_inc > largest_q) begin
                largest_d = run_inc;
              end
            end else begin
              run_d = '0;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      free_q <= TOTAL;
      rsv_q <= COUNT_W'(1);
      out_valid_q <= 1'b0;
      op_q <= OP_INIT;
      status_q <= ST_OK;
      idx_q <= '0;
      pass2_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q <= free_d;
      op_q <= op_d;
      status_q <= status_d;
      idx_q <= idx_d;
      pass2_q <= pass2_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        rsv_q <= cfg_wdata_i;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d; count_q <= count_d; lim_q <= lim_d;
    run_q <= run_d; first_q <= first_d; largest_q <= largest_d;
    runs_q <= runs_d; total_q <= total_d;
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      // status, alloc_start, free_total, largest_run, run_count, count_mismatch
      out_data_q <= {3'b000,
                     ((op_q == OP_QUERY) && (total_q != free_q)),
                     RUNS_W'(runs_q),
                     COUNT_W'(largest_q),
                     COUNT_W'(free_q),
                     ((op_q == OP_ALLOC && status_q == ST_OK) ?
                      START_W'(start_q) : {START_W{1'b0}}),
                     status_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BCBA_ASSERT(a_free_bounded, free_q <= TOTAL, "free count above total")
  `BCBA_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "ready while busy")
  `BCBA_ASSERT_NEXT(a_single_pass, state_q == S_SCAN && wrap && op_q != OP_ALLOC,
                    state_q == S_DONE, "scan did not end after one turn")
  `BCBA_ASSERT(a_pass2_found, !pass2_q || found_q, "second pass without a run")

endmodule

@@ hw/rtl/bitmap_contiguous_block_allocator.sv @@
// Bitmap first-fit contiguous block allocator, top level.
// Builds the ring of bcba_cell and the bcba_ctrl sequencer; uses bcba_pkg.
//
// Input channel s_axis: tuser carries the operation (init, alloc, free,
// query); tdata carries free_start and the block count. Output channel m_axis
// carries one result per input. cfg_we_i writes reserved_blocks.
// The map is a ring of one-bit cells; an operation rotates it one full turn,
// one block per cycle, while the sequencer reads the head and rewrites the
// tail. An alloc that finds a run turns it twice (a search turn and a marking
// turn); a zero count or a count above the free count answers without a turn.
// One item is worked at a time; s_axis_tready is high while idle.
// The result sits in an output register: a stalled receiver holds it while
// the next item is already taken and worked; a second result waits for it.
// Reset: all blocks free, free count NUM_BLOCKS, reserved_blocks 1.
module bitmap_contiguous_block_allocator import bcba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [9:0] free_start, [20:10] blk_cnt
  input  logic [IN_W-1:0]     s_axis_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] status, [11:2] alloc_start, [22:12] free_total,
  // [33:23] largest_run, [43:34] run_count, [44] count_mismatch
  output logic [OUT_W-1:0]    m_axis_tdata
);

  logic [NUM_BLOCKS-1:0] map_q;
  ring_ctl_t ring;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    logic d;
    if (i == NUM_BLOCKS - 1) begin : g_tail
      assign d = ring.tail_bit;
    end else begin : g_mid
      assign d = map_q[i+1];
    end
    bcba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .d_i     (d),
      .q_o     (map_q[i])
    );
  end

  bcba_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_start_i  (s_axis_tdata[9:0]),
    .in_count_i  (s_axis_tdata[20:10]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .head_i      (map_q[0]),
    .ring_o      (ring)
  );

endmodule

@@ test/bitmap_contiguous_block_allocator_tb.sv @@
// Self-checking testbench for the bitmap first-fit contiguous block allocator.
// Drives operations over the stream ports and checks each result against a
// local model of the map; depends on bcba_pkg and the allocator top level.
`timescale 1ns / 1ps

module bitmap_contiguous_block_allocator_tb;
  import bcba_pkg::*;

  localparam int unsigned NBLK = NUM_BLOCKS_DEF;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

  typedef struct packed {
    logic [10:0]     cnt;
    logic [9:0]      fstart;
    op_e             op;
  } req_t;

  typedef struct packed {
    logic            mismatch;
    logic [9:0]      runs;
    logic [10:0]     largest;
    logic [10:0]     free_total;
    logic [9:0]      astart;
    status_e         status;
  } resp_t;

  typedef struct {
    req_t  req;
    bit    has_exp;
    resp_t exp;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]   s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  bitmap_contiguous_block_allocator DUT (.*);

  always #4 clk_i = ~clk_i;

  // model state
  bit          used_map [NBLK];
  int unsigned free_cnt;
  int unsigned reserved;

  resp_t       pending_q [$];
  int          errors = 0;
  longint unsigned cycles = 0;
  bit          stall_mode = 0;

  function automatic resp_t predict_op(req_t r);
    resp_t o;
    int unsigned run, first, lim, total;
    bit found;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_INIT: begin
        lim = (reserved > NBLK) ? NBLK : reserved;
        for (int i = 0; i < NBLK; i++) used_map[i] = (i < lim);
        free_cnt = NBLK - lim;
      end
      OP_ALLOC: begin
        if (r.cnt == 0) o.status = ST_INVALID;
        else if (r.cnt > free_cnt) o.status = ST_NOSPACE;
        else begin
          run = 0; first = 0; found = 0;
          for (int i = 0; i < NBLK && !found; i++) begin
            if (!used_map[i]) begin
              if (run == 0) first = i;
              run++;
              if (run == r.cnt) found = 1;
            end else run = 0;
          end
          if (!found) o.status = ST_NOSPACE;
          else begin
            for (int i = 0; i < r.cnt; i++) used_map[first + i] = 1;
            free_cnt -= r.cnt;
            o.astart = 10'(first);
          end
        end
      end
      OP_FREE: begin
        if (r.cnt == 0) o.status = ST_INVALID;
        else begin
          for (int i = 0; i < r.cnt; i++)
            if (r.fstart + i < NBLK) used_map[r.fstart + i] = 0;
          free_cnt += r.cnt;
          if (free_cnt > NBLK) free_cnt = NBLK;
        end
      end
      default: begin
        run = 0; total = 0;
        for (int i = 0; i < NBLK; i++) begin
          if (!used_map[i]) begin
            if (run == 0) o.runs++;
            run++; total++;
            if (run > o.largest) o.largest = 11'(run);
          end else run = 0;
        end
        o.mismatch = (total != free_cnt);
      end
    endcase
    o.free_total = 11'(free_cnt);
    return o;
  endfunction

  // receiver with its own stall pattern; sampling at posedge sees pre-NBA values
  always @(posedge clk_i) begin
    resp_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = resp_t'(m_axis_tdata[44:0]);
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp st=%0d as=%0d ft=%0d lr=%0d rc=%0d mm=%0d",
                     want.status, want.astart, want.free_total, want.largest,
                     want.runs, want.mismatch);
            $display("          got st=%0d as=%0d ft=%0d lr=%0d rc=%0d mm=%0d",
                     got.status, got.astart, got.free_total, got.largest,
                     got.runs, got.mismatch);
          end
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[bitmap_contiguous_block_allocator] ERROR");
      $finish;
    end
  end

  task automatic send_item(req_t r, bit has_exp, resp_t exp);
    resp_t p;
    p = predict_op(r);
    if (has_exp && p !== exp) begin
      errors++;
      if (errors <= 10) $display("directed row expectation %h differs from model %h", exp, p);
    end
    pending_q.push_back(has_exp ? exp : p);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {3'b0, r.cnt, r.fstart};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_cycles(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // write the register only once the block has drained
  task automatic write_reserved(int unsigned v);
    idle_cycles(1);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * NBLK + 10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= COUNT_W'(v);
    reserved = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t mk(op_e op, int unsigned fs, int unsigned c);
    req_t r;
    r.op = op; r.fstart = 10'(fs); r.cnt = 11'(c);
    return r;
  endfunction

  function automatic resp_t ex(status_e st, int unsigned as, int unsigned ft,
                               int unsigned lr, int unsigned rc, bit mm);
    resp_t o;
    o.status = st; o.astart = 10'(as); o.free_total = 11'(ft);
    o.largest = 11'(lr); o.runs = 10'(rc); o.mismatch = mm;
    return o;
  endfunction

  function automatic req_t rand_req();
    int unsigned k;
    req_t r;
    k = $urandom_range(0, 99);
    r.fstart = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 9) == 0) r.cnt = 11'($urandom_range(0, 2047));
    else if ($urandom_range(0, 4) == 0) r.cnt = 11'($urandom_range(0, 1024));
    else r.cnt = 11'($urandom_range(1, 40));
    if (k < 3) r.op = OP_INIT;
    else if (k < 55) r.op = OP_ALLOC;
    else if (k < 88) r.op = OP_FREE;
    else r.op = OP_QUERY;
    return r;
  endfunction

  initial begin
    row_t rows [$];
    int burst;
    reserved = 1;
    free_cnt = NBLK;
    foreach (used_map[i]) used_map[i] = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: all blocks free, reserved_blocks is 1
    rows.push_back('{mk(OP_QUERY, 0, 0), 1, ex(ST_OK, 0, 1024, 1024, 1, 0)});
    rows.push_back('{mk(OP_ALLOC, 0, 0), 1, ex(ST_INVALID, 0, 1024, 0, 0, 0)});
    rows.push_back('{mk(OP_FREE, 5, 0), 1, ex(ST_INVALID, 0, 1024, 0, 0, 0)});
    rows.push_back('{mk(OP_ALLOC, 0, 1025), 1, ex(ST_NOSPACE, 0, 1024, 0, 0, 0)});
    rows.push_back('{mk(OP_ALLOC, 0, 2047), 1, ex(ST_NOSPACE, 0, 1024, 0, 0, 0)});
    rows.push_back('{mk(OP_INIT, 0, 0), 1, ex(ST_OK, 0, 1023, 0, 0, 0)});
    rows.push_back('{mk(OP_ALLOC, 0, 1023), 1, ex(ST_OK, 1, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_ALLOC, 0, 1), 1, ex(ST_NOSPACE, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_QUERY, 0, 0), 1, ex(ST_OK, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_FREE, 1023, 2047), 1, ex(ST_OK, 0, 1024, 0, 0, 0)});
    rows.push_back('{mk(OP_QUERY, 0, 0), 1, ex(ST_OK, 0, 1024, 1, 1, 1)});
    rows.push_back('{mk(OP_FREE, 0, 1024), 0, '0});
    rows.push_back('{mk(OP_ALLOC, 0, 1024), 1, ex(ST_OK, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(OP_FREE, 100, 10), 0, '0});
    rows.push_back('{mk(OP_FREE, 500, 20), 0, '0});
    rows.push_back('{mk(OP_ALLOC, 0, 15), 0, '0});   // skips the short hole
    rows.push_back('{mk(OP_ALLOC, 0, 30), 0, '0});   // more than is free, no space
    rows.push_back('{mk(OP_FREE, 0, 1), 0, '0});
    rows.push_back('{mk(OP_QUERY, 0, 0), 0, '0});
    rows.push_back('{mk(OP_INIT, 0, 0), 0, '0});
    foreach (rows[i]) send_item(rows[i].req, rows[i].has_exp, rows[i].exp);

    // reserved beyond total, then the other extremes
    write_reserved(2047);
    send_item(mk(OP_INIT, 0, 0), 1, ex(ST_OK, 0, 0, 0, 0, 0));
    send_item(mk(OP_QUERY, 0, 0), 1, ex(ST_OK, 0, 0, 0, 0, 0));
    write_reserved(0);
    send_item(mk(OP_INIT, 0, 0), 1, ex(ST_OK, 0, 1024, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_reserved(1024);
        1: write_reserved($urandom_range(0, 1024));
        2: write_reserved(0);
        default: write_reserved($urandom_range(0, 64));
      endcase
      send_item(mk(OP_INIT, 0, 0), 0, '0);
      for (int n = 0; n < RANDOM_ITEMS / 4; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < RANDOM_ITEMS / 4; b++, n++)
          send_item(rand_req(), 0, '0);
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 40));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * NBLK + 10) @(posedge clk_i);
    if (errors == 0)
      $display("[bitmap_contiguous_block_allocator] OK");
    else
      $display("[bitmap_contiguous_block_allocator] ERROR");
    $finish;
  end

endmodule
